/* src/pdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pdr_pkg;
	localparam int WORD_W = 32;
	localparam int STEP_W = 16;
	localparam int DPM_W  = 24;
	localparam int GRAV_W = 21;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;
	localparam int DVD_W  = 36;
	localparam int QUO_W  = 34;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t CFG_DRAG = 1'b0;
	localparam cfg_idx_t CFG_GRAV = 1'b1;

	localparam logic [GRAV_W-1:0] GRAV_RESET = 21'd642253;
	// (2^33 + 1) / 3, exact reciprocal of 3 for numerators below 2^33
	localparam logic [31:0] RECIP3 = 32'd2863311531;
endpackage
`default_nettype wire

/* src/pdr_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pdr_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [pdr_pkg::STEP_W-1:0] step_size;
	pdr_pkg::word_t start_range;
	pdr_pkg::word_t start_range_speed;
	pdr_pkg::word_t start_height;
	pdr_pkg::word_t start_climb_speed;
	modport source(output valid, kind, step_size, start_range, start_range_speed,
		start_height, start_climb_speed, input ready);
	modport sink(input valid, kind, step_size, start_range, start_range_speed,
		start_height, start_climb_speed, output ready);
endinterface
`default_nettype wire

/* src/pdr_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pdr_res_if;
	logic valid;
	logic ready;
	pdr_pkg::word_t range_pos;
	pdr_pkg::word_t range_speed;
	pdr_pkg::word_t height_pos;
	pdr_pkg::word_t climb_speed;
	logic [pdr_pkg::WORD_W-1:0] elapsed_time;
	logic saturated;
	modport source(output valid, range_pos, range_speed, height_pos, climb_speed,
		elapsed_time, saturated, input ready);
	modport sink(input valid, range_pos, range_speed, height_pos, climb_speed,
		elapsed_time, saturated, output ready);
endinterface
`default_nettype wire

/* src/pdr_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module pdr_mul (
	input  logic clk,
	input  logic signed [pdr_pkg::MUL_W-1:0] a,
	input  logic signed [pdr_pkg::MUL_W-1:0] b,
	output logic signed [pdr_pkg::PROD_W-1:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

/* src/pdr_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module pdr_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pdr_pkg::RAD_W-1:0] radicand,
	output logic done,
	output logic [pdr_pkg::ROOT_W-1:0] root
);
	localparam int CW = $clog2(pdr_pkg::ROOT_W);
	localparam int RW = pdr_pkg::ROOT_W + 2;

	logic [pdr_pkg::RAD_W-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [pdr_pkg::ROOT_W-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [RW+1:0] r2, trial;

	// one result bit per cycle, two radicand bits shifted in
	assign r2 = {rem_q, rad_q[pdr_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(pdr_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[pdr_pkg::RAD_W-3:0], 2'b00};
			if (r2 >= trial) begin
				rem_q <= RW'(r2 - trial);
				root_q <= {root_q[pdr_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= RW'(r2);
				root_q <= {root_q[pdr_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

/* src/pdr_div6.sv */
`timescale 1ns / 1ps
`default_nettype none
module pdr_div6 (
	input  logic clk,
	input  logic start,
	input  logic [pdr_pkg::DVD_W-1:0] dividend,
	input  logic [pdr_pkg::PROD_W-1:0] prod,
	output logic [31:0] mul_op,
	output logic [pdr_pkg::QUO_W-1:0] quotient
);
	logic [32:0] half_q;
	logic [33:0] hi_sum;

	// floor(d / 6) = floor(floor(d / 2) / 3); dividend stays below 2^34
	always_ff @(posedge clk) begin
		if (start) half_q <= dividend[33:1];
	end

	// low 32 bits go through the shared multiplier, bit 32 adds RECIP3 << 32 here
	assign mul_op = half_q[31:0];
	assign hi_sum = prod[pdr_pkg::PROD_W-1:32]
		+ (half_q[32] ? {2'b00, pdr_pkg::RECIP3} : 34'd0);
	assign quotient = pdr_pkg::QUO_W'(hi_sum >> 1);
endmodule
`default_nettype wire

/* src/projectile_drag_rk4_step.sv */
// Projectile state with quadratic drag, advanced by fourth-order Runge-Kutta steps.
// req channel (valid/ready): kind 1 loads the state from the start_* fields and clears
// the flight clock; kind 0 advances one step of length step_size (Q0.16 s).
// res channel (valid/ready): one result per request with the new state, elapsed time
// and a flag telling whether any value clipped during the request.
// cfg port: cfg_we writes cfg_data to register cfg_idx (0 drag_per_mass, 1 gravity).
// A step request runs four derivative passes, each waiting on the bit-serial square root,
// on one shared 33x33 multiplier, then for each state value the rounded divide by six,
// done as a reciprocal multiply on the same multiplier, then loads the result register.
// A launch request goes from idle straight to the result state, which loads the result
// register once it is free. One request is in work at a time; req.ready is high only
// while the sequencer is idle, so a new request is not taken before the last one's
// result has been loaded into the output register.
// The result sits in an output register; a stalled receiver holds it there and the
// next request is accepted meanwhile, but its result waits until that register frees.
// arst_n clears the state and clock to zero, drag to zero and gravity to 9.8 m/s^2.
`timescale 1ns / 1ps
`default_nettype none
module projectile_drag_rk4_step #(
	parameter int STATE_LEN = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  pdr_pkg::cfg_idx_t cfg_idx,
	input  logic [pdr_pkg::DPM_W-1:0] cfg_data,
	pdr_req_if.sink req,
	pdr_res_if.source res
);
	localparam int IW = $clog2(STATE_LEN);
	localparam logic [IW-1:0] I_X = IW'(0);
	localparam logic [IW-1:0] I_VX = IW'(1);
	localparam logic [IW-1:0] I_Y = IW'(2);
	localparam logic [IW-1:0] I_VY = IW'(3);
	localparam logic [IW-1:0] I_LAST = IW'(STATE_LEN - 1);
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQX = 4'd1;
	localparam logic [3:0] S_SQY = 4'd2;
	localparam logic [3:0] S_SUM = 4'd3;
	localparam logic [3:0] S_ROOT = 4'd4;
	localparam logic [3:0] S_TMUL = 4'd5;
	localparam logic [3:0] S_TGET = 4'd6;
	localparam logic [3:0] S_DXMUL = 4'd7;
	localparam logic [3:0] S_DYMUL = 4'd8;
	localparam logic [3:0] S_DYEND = 4'd9;
	localparam logic [3:0] S_HK = 4'd10;
	localparam logic [3:0] S_HKEND = 4'd11;
	localparam logic [3:0] S_FIN = 4'd12;
	localparam logic [3:0] S_DIV = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;
	localparam logic [3:0] S_DMUL = 4'd15;

	function automatic pdr_pkg::word_t clip32(input logic signed [63:0] v);
		if (v > MAXV) return 32'sh7FFFFFFF;
		else if (v < MINV) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > MAXV) || (v < MINV);
	endfunction

	function automatic logic [31:0] mag32(input pdr_pkg::word_t v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	logic [3:0] state_q;
	logic [1:0] stage_q;
	logic [IW-1:0] idx_q;
	pdr_pkg::word_t st_q [STATE_LEN];
	pdr_pkg::word_t tmp_q [STATE_LEN];
	pdr_pkg::word_t k_q [STATE_LEN];
	logic signed [51:0] acc_q [STATE_LEN];
	logic [63:0] sq_q;
	logic [31:0] t_q;
	logic [pdr_pkg::STEP_W-1:0] h_q;
	logic [31:0] clk_q;
	logic sat_q;
	logic [pdr_pkg::DPM_W-1:0] dpm_q;
	logic [pdr_pkg::GRAV_W-1:0] grav_q;

	logic res_valid_q;
	logic res_load;
	pdr_pkg::word_t o_x_q, o_vx_q, o_y_q, o_vy_q;
	logic [31:0] o_t_q;
	logic o_sat_q;

	logic signed [pdr_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [pdr_pkg::PROD_W-1:0] prod;
	logic sqrt_start, sqrt_done, div_start;
	logic [pdr_pkg::ROOT_W-1:0] speed;
	logic [pdr_pkg::QUO_W-1:0] quo;
	logic [31:0] div_op;

	logic [31:0] mx, my;
	logic [63:0] sum_sq;
	logic [56:0] t_rnd;
	logic [63:0] dd_rnd;
	logic signed [63:0] dd_s, d1_raw, d3_raw;
	logic signed [48:0] p49;
	logic [48:0] hmag, hq_rnd;
	logic [32:0] hq;
	logic signed [63:0] hv;
	logic signed [51:0] p52, acc_nx;
	logic [51:0] amag;
	logic [pdr_pkg::DVD_W-1:0] div_in;
	logic signed [63:0] fv;
	logic [32:0] clk_sum;

	assign mx = mag32(tmp_q[I_VX]);
	assign my = mag32(tmp_q[I_VY]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQX: begin
				mul_a = {1'b0, mx};
				mul_b = {1'b0, mx};
			end
			S_SQY: begin
				mul_a = {1'b0, my};
				mul_b = {1'b0, my};
			end
			S_TMUL: begin
				mul_a = {9'd0, dpm_q};
				mul_b = {1'b0, speed};
			end
			S_DXMUL: begin
				mul_a = {1'b0, t_q};
				mul_b = {1'b0, mx};
			end
			S_DYMUL: begin
				mul_a = {1'b0, t_q};
				mul_b = {1'b0, my};
			end
			S_HK: begin
				mul_a = {17'd0, h_q};
				mul_b = {k_q[idx_q][31], k_q[idx_q]};
			end
			S_DMUL: begin
				mul_a = {1'b0, div_op};
				mul_b = {1'b0, pdr_pkg::RECIP3};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pdr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod));

	assign sum_sq = sq_q + prod[63:0];
	assign sqrt_start = (state_q == S_SUM);

	pdr_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(sum_sq),
		.done(sqrt_done), .root(speed)
	);

	// drag products, shared by both axes
	assign t_rnd = prod[56:0] + 57'd8388608;
	assign dd_rnd = prod[63:0] + 64'd32768;
	assign dd_s = signed'({16'd0, dd_rnd[63:16]});
	assign d1_raw = tmp_q[I_VX][31] ? dd_s : -dd_s;
	assign d3_raw = (tmp_q[I_VY][31] ? dd_s : -dd_s) - signed'({43'd0, grav_q});

	// h * k rounded half away from zero, shift by 17 for half steps, 16 for the full one
	assign p49 = prod[48:0];
	assign hmag = p49[48] ? 49'(-p49) : 49'(p49);
	assign hq_rnd = hmag + ((stage_q == 2'd2) ? 49'd32768 : 49'd65536);
	assign hq = (stage_q == 2'd2) ? 33'(hq_rnd >> 16) : 33'(hq_rnd >> 17);
	assign hv = 64'(st_q[idx_q]) + (p49[48] ? -signed'({31'd0, hq}) : signed'({31'd0, hq}));
	assign p52 = 52'(p49);
	assign acc_nx = acc_q[idx_q] + ((stage_q == 2'd1 || stage_q == 2'd2) ? (p52 <<< 1) : p52);

	// divide by 6 * 2^16 with rounding: floor((floor(a / 2^16) + 3) / 6)
	assign amag = acc_q[idx_q][51] ? 52'(-acc_q[idx_q]) : 52'(acc_q[idx_q]);
	assign div_in = pdr_pkg::DVD_W'(amag >> 16) + 36'd3;
	assign div_start = (state_q == S_FIN);

	pdr_div6 u_div (
		.clk(clk), .start(div_start), .dividend(div_in), .prod(prod),
		.mul_op(div_op), .quotient(quo)
	);

	assign fv = 64'(st_q[idx_q])
		+ (acc_q[idx_q][51] ? -signed'({30'd0, quo}) : signed'({30'd0, quo}));
	assign clk_sum = {1'b0, clk_q} + {17'd0, h_q};

	assign req.ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpm_q <= '0;
			grav_q <= pdr_pkg::GRAV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pdr_pkg::CFG_DRAG: dpm_q <= cfg_data;
				pdr_pkg::CFG_GRAV: grav_q <= cfg_data[pdr_pkg::GRAV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= '0;
			idx_q <= '0;
			clk_q <= '0;
			sat_q <= 1'b0;
			for (int i = 0; i < STATE_LEN; i++) st_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						sat_q <= 1'b0;
						stage_q <= '0;
						idx_q <= '0;
						if (req.kind) begin
							st_q[I_X] <= req.start_range;
							st_q[I_VX] <= req.start_range_speed;
							st_q[I_Y] <= req.start_height;
							st_q[I_VY] <= req.start_climb_speed;
							clk_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SQX;
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SUM;
				S_SUM: state_q <= S_ROOT;
				S_ROOT: if (sqrt_done) state_q <= S_TMUL;
				S_TMUL: state_q <= S_TGET;
				S_TGET: state_q <= S_DXMUL;
				S_DXMUL: state_q <= S_DYMUL;
				S_DYMUL: begin
					if (ovf32(d1_raw)) sat_q <= 1'b1;
					state_q <= S_DYEND;
				end
				S_DYEND: begin
					if (ovf32(d3_raw)) sat_q <= 1'b1;
					state_q <= S_HK;
				end
				S_HK: state_q <= S_HKEND;
				S_HKEND: begin
					if (stage_q != 2'd3 && ovf32(hv)) sat_q <= 1'b1;
					if (idx_q == I_LAST) begin
						idx_q <= '0;
						if (stage_q == 2'd3) begin
							state_q <= S_FIN;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= S_SQX;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_HK;
					end
				end
				S_FIN: state_q <= S_DMUL;
				S_DMUL: state_q <= S_DIV;
				S_DIV: begin
					st_q[idx_q] <= clip32(fv);
					if (ovf32(fv) || (idx_q == I_LAST && clk_sum[32])) sat_q <= 1'b1;
					if (idx_q == I_LAST) begin
						// flight clock saturates at all ones
						clk_q <= clk_sum[32] ? '1 : clk_sum[31:0];
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_DONE: begin
					if (res_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				h_q <= req.step_size;
				for (int i = 0; i < STATE_LEN; i++) begin
					tmp_q[i] <= st_q[i];
					acc_q[i] <= '0;
				end
			end
			S_SQY: sq_q <= prod[63:0];
			S_TGET: t_q <= t_rnd[55:24];
			S_DYMUL: k_q[I_VX] <= clip32(d1_raw);
			S_DYEND: begin
				k_q[I_VY] <= clip32(d3_raw);
				k_q[I_X] <= tmp_q[I_VX];
				k_q[I_Y] <= tmp_q[I_VY];
			end
			S_HKEND: begin
				acc_q[idx_q] <= acc_nx;
				if (stage_q != 2'd3) tmp_q[idx_q] <= clip32(hv);
			end
			S_DONE: begin
				if (res_load) begin
					o_x_q <= st_q[I_X];
					o_vx_q <= st_q[I_VX];
					o_y_q <= st_q[I_Y];
					o_vy_q <= st_q[I_VY];
					o_t_q <= clk_q;
					o_sat_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid = res_valid_q;
	assign res.range_pos = o_x_q;
	assign res.range_speed = o_vx_q;
	assign res.height_pos = o_y_q;
	assign res.climb_speed = o_vy_q;
	assign res.elapsed_time = o_t_q;
	assign res.saturated = o_sat_q;

`ifndef SYNTHESIS
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while a previous one was still in work");
	a_launch_short: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.kind) |=> (state_q == S_DONE))
		else $error("launch did not go straight to result");
	a_root_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == S_ROOT))
		else $error("square root finished outside its wait state");
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.range_pos)
			&& $stable(res.height_pos) && $stable(res.elapsed_time)
			&& $stable(res.saturated)))
		else $error("stalled result changed before it was taken");
`endif
endmodule
`default_nettype wire

/* sim/tb_projectile_drag_rk4_step.sv */
`timescale 1ns / 1ps
module tb_projectile_drag_rk4_step;

	typedef struct {
		pdr_pkg::word_t range_pos;
		pdr_pkg::word_t range_speed;
		pdr_pkg::word_t height_pos;
		pdr_pkg::word_t climb_speed;
		logic [pdr_pkg::WORD_W-1:0] elapsed_time;
		logic saturated;
	} flight_state_t;

	class flight_scoreboard;
		longint unsigned drag;
		longint unsigned grav;
		int traj[4];
		longint unsigned clock_q;
		flight_state_t expected_q[$];
		int errors;

		function new();
			drag = 0;
			grav = 64'(pdr_pkg::GRAV_RESET);
			foreach (traj[i]) traj[i] = 0;
			clock_q = 0;
			errors = 0;
		endfunction

		function void set_reg(pdr_pkg::cfg_idx_t idx, longint unsigned val);
			if (idx == pdr_pkg::CFG_DRAG) drag = val & 64'hFFFFFF;
			else grav = val & 64'h1FFFFF;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int clip(longint v, ref bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 32'sh7FFFFFFF;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return 32'sh80000000;
			end
			return int'(v);
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		// divide rounding half away from zero
		function longint rdiv(longint num, longint unsigned den);
			longint unsigned q;
			q = (mag(num) + den / 2) / den;
			return num < 0 ? -longint'(q) : longint'(q);
		endfunction

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void slope(input int s[4], output int d[4], ref bit sat);
			longint unsigned mx, my, spd, t;
			longint dx, dy;
			mx = mag(s[1]);
			my = mag(s[3]);
			spd = isqrt(mx * mx + my * my);
			t = (drag * spd + (64'd1 << 23)) >> 24;
			dx = longint'((t * mx + 32768) >> 16);
			dy = longint'((t * my + 32768) >> 16);
			d[0] = s[1];
			d[2] = s[3];
			d[1] = clip(s[1] < 0 ? dx : -dx, sat);
			d[3] = clip((s[3] < 0 ? dy : -dy) - longint'(grav), sat);
		endfunction

		function void advance(longint h, ref bit sat);
			int k1[4], k2[4], k3[4], k4[4], tmp[4];
			longint sum;
			slope(traj, k1, sat);
			foreach (tmp[i]) tmp[i] = clip(longint'(traj[i]) + rdiv(h * k1[i], 131072), sat);
			slope(tmp, k2, sat);
			foreach (tmp[i]) tmp[i] = clip(longint'(traj[i]) + rdiv(h * k2[i], 131072), sat);
			slope(tmp, k3, sat);
			foreach (tmp[i]) tmp[i] = clip(longint'(traj[i]) + rdiv(h * k3[i], 65536), sat);
			slope(tmp, k4, sat);
			foreach (traj[i]) begin
				sum = longint'(k1[i]) + 2 * longint'(k2[i]) + 2 * longint'(k3[i])
					+ longint'(k4[i]);
				traj[i] = clip(longint'(traj[i]) + rdiv(h * sum, 6 * 65536), sat);
			end
		endfunction

		function void note_request(logic kind, logic [pdr_pkg::STEP_W-1:0] h,
				pdr_pkg::word_t a, pdr_pkg::word_t b, pdr_pkg::word_t c, pdr_pkg::word_t d);
			bit sat;
			flight_state_t e;
			sat = 0;
			if (kind) begin
				traj[0] = a;
				traj[1] = b;
				traj[2] = c;
				traj[3] = d;
				clock_q = 0;
			end else begin
				advance(longint'(h), sat);
				clock_q = clock_q + h;
				if (clock_q > 64'hFFFFFFFF) begin
					clock_q = 64'hFFFFFFFF;
					sat = 1;
				end
			end
			e.range_pos = traj[0];
			e.range_speed = traj[1];
			e.height_pos = traj[2];
			e.climb_speed = traj[3];
			e.elapsed_time = clock_q[31:0];
			e.saturated = sat;
			expected_q.push_back(e);
		endfunction

		function void check_result(flight_state_t got);
			flight_state_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.range_pos !== e.range_pos) begin
				$error("range_pos expected %0d got %0d", e.range_pos, got.range_pos);
				errors++;
			end
			if (got.range_speed !== e.range_speed) begin
				$error("range_speed expected %0d got %0d", e.range_speed, got.range_speed);
				errors++;
			end
			if (got.height_pos !== e.height_pos) begin
				$error("height_pos expected %0d got %0d", e.height_pos, got.height_pos);
				errors++;
			end
			if (got.climb_speed !== e.climb_speed) begin
				$error("climb_speed expected %0d got %0d", e.climb_speed, got.climb_speed);
				errors++;
			end
			if (got.elapsed_time !== e.elapsed_time) begin
				$error("elapsed_time expected %0d got %0d", e.elapsed_time,
					got.elapsed_time);
				errors++;
			end
			if (got.saturated !== e.saturated) begin
				$error("saturated expected %0d got %0d", e.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	localparam int QUIET_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	pdr_pkg::cfg_idx_t cfg_idx;
	logic [pdr_pkg::DPM_W-1:0] cfg_data;

	pdr_req_if req_if();
	pdr_res_if res_if();

	projectile_drag_rk4_step u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_if),
		.res(res_if)
	);

	flight_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int res_hold;
	int quiet;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver
	initial begin
		flight_state_t got;
		res_if.ready <= 0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.range_pos = res_if.range_pos;
				got.range_speed = res_if.range_speed;
				got.height_pos = res_if.height_pos;
				got.climb_speed = res_if.climb_speed;
				got.elapsed_time = res_if.elapsed_time;
				got.saturated = res_if.saturated;
				sb.check_result(got);
			end
			if (res_hold > 0) begin
				res_hold--;
				res_if.ready <= 0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_projectile_drag_rk4_step: FAIL");
				$finish;
			end
		end
	end

	task automatic send_request(logic kind, logic [pdr_pkg::STEP_W-1:0] h,
			pdr_pkg::word_t a, pdr_pkg::word_t b, pdr_pkg::word_t c, pdr_pkg::word_t d);
		req_if.valid <= 1;
		req_if.kind <= kind;
		req_if.step_size <= h;
		req_if.start_range <= a;
		req_if.start_range_speed <= b;
		req_if.start_height <= c;
		req_if.start_climb_speed <= d;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(kind, h, a, b, c, d);
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_if.valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// only called once the block is drained
	task automatic write_reg(pdr_pkg::cfg_idx_t idx, logic [pdr_pkg::DPM_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, 64'(val));
		@(posedge clk);
	endtask

	function automatic pdr_pkg::word_t rand_word();
		return pdr_pkg::word_t'($urandom);
	endfunction

	function automatic pdr_pkg::word_t rand_speed();
		pdr_pkg::word_t v;
		v = pdr_pkg::word_t'($urandom_range(0, 600 << 16));
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic step_plain(logic [pdr_pkg::STEP_W-1:0] h);
		send_request(1'b0, h, rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	// one launch followed by a run of steps
	task automatic fly();
		int n;
		logic [pdr_pkg::STEP_W-1:0] h;
		if ($urandom_range(9) == 0)
			send_request(1'b1, 16'(rand_word()), rand_word(), rand_word(), rand_word(),
				rand_word());
		else
			send_request(1'b1, 16'(rand_word()),
				pdr_pkg::word_t'($urandom_range(0, 1000 << 16)) - (500 << 16),
				rand_speed(), pdr_pkg::word_t'($urandom_range(0, 200 << 16)), rand_speed());
		n = $urandom_range(2, 8);
		repeat (n) begin
			case ($urandom_range(9))
				0: h = 16'($urandom);
				1: h = 16'd0;
				default: h = 16'($urandom_range(1, 8000));
			endcase
			step_plain(h);
		end
	endtask

	initial begin
		int items;
		sb = new();
		arst_n = 0;
		cfg_we <= 0;
		cfg_idx <= pdr_pkg::CFG_DRAG;
		cfg_data <= 0;
		req_if.valid <= 0;
		req_if.kind <= 0;
		req_if.step_size <= 0;
		req_if.start_range <= 0;
		req_if.start_range_speed <= 0;
		req_if.start_height <= 0;
		req_if.start_climb_speed <= 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		res_hold = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero speed with reset gravity, zero and full steps
		step_plain(16'd0);
		step_plain(16'hFFFF);
		send_request(1'b1, 16'hFFFF, 0, 0, 0, 0);
		step_plain(16'd0);
		step_plain(16'hFFFF);
		// field extremes, clipping
		send_request(1'b1, 16'h0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
		step_plain(16'hFFFF);
		send_request(1'b1, 16'h1234, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF);
		step_plain(16'hFFFF);
		drain();
		write_reg(pdr_pkg::CFG_DRAG, 24'hFFFFFF);
		write_reg(pdr_pkg::CFG_GRAV, 24'h1FFFFF);
		send_request(1'b1, 16'd0, 0, 100 << 16, 0, 50 << 16);
		step_plain(16'd6554);
		step_plain(16'hFFFF);
		send_request(1'b1, 16'd0, 0, 32'sh7FFFFFFF, 0, 32'sh80000000);
		step_plain(16'd100);
		drain();
		write_reg(pdr_pkg::CFG_GRAV, 24'd0);
		write_reg(pdr_pkg::CFG_DRAG, 24'd0);
		send_request(1'b1, 16'd0, 0, 0, 0, 0);
		step_plain(16'd5000);

		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 66; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 66; end
				3: begin send_idle_pct = 30; recv_stall_pct = 30; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			case (phase)
				0: begin
					write_reg(pdr_pkg::CFG_DRAG, 24'd1200);
					write_reg(pdr_pkg::CFG_GRAV, 24'(pdr_pkg::GRAV_RESET));
				end
				1: begin
					write_reg(pdr_pkg::CFG_DRAG, 24'($urandom));
					write_reg(pdr_pkg::CFG_GRAV, 24'($urandom));
				end
				2: begin
					write_reg(pdr_pkg::CFG_DRAG, 24'hFFFFFF);
					write_reg(pdr_pkg::CFG_GRAV, 24'h1FFFFF);
				end
				3: begin
					write_reg(pdr_pkg::CFG_DRAG, 24'd0);
					write_reg(pdr_pkg::CFG_GRAV, 24'd0);
				end
				default: begin
					write_reg(pdr_pkg::CFG_DRAG, 24'($urandom_range(0, 20000)));
					write_reg(pdr_pkg::CFG_GRAV, 24'(pdr_pkg::GRAV_RESET));
				end
			endcase
			items = 0;
			while (items < 140) begin
				fly();
				items += 6;
				if (phase == 4 && items >= 60 && items < 66) begin
					// long receiver hold-off while requests keep coming
					res_hold = 1500;
				end
				if (phase == 1 && items >= 60 && items < 66) drain();
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_projectile_drag_rk4_step: PASS");
		else
			$display("tb_projectile_drag_rk4_step: FAIL");
		$finish;
	end
endmodule
